/* hw/rtl/i2cbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int CMD_W       = 3;
   localparam int PHASE_W     = 2;
   localparam int BITCNT_W    = 4;
   localparam int TICK_W      = 8;
   localparam int PULSE_W     = 4;
   localparam int BYTE_W      = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TICK_W-1:0]   PHASE_TICKS_RESET = 8'd7;
   localparam logic [BITCNT_W-1:0] BITS_PER_BYTE     = 4'd8;
   localparam logic [PULSE_W-1:0]  UNLOCK_PULSES     = 4'd9;

   localparam logic [CMD_W-1:0] CMD_IDLE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ACK    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd5;

   localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
   localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
   localparam logic [PHASE_W-1:0] PH_2 = 2'd2;
   localparam logic [PHASE_W-1:0] PH_3 = 2'd3;

   // one classified tick as it travels through the queue
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] tx_byte;
      logic              ack_level;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic              bus_busy;
      logic              ready_res;
      logic              done_res;
      logic              ack_sampled;
      logic [BYTE_W-1:0] rx_byte;
      logic              sda_out;
      logic              scl_out;
   } result_type;

endpackage

/* hw/rtl/i2cbe_front.sv */
// ----------------------------------------------------------------------------
// i2cbe_front
// Unpacks an incoming tick and classifies its command code.
// ----------------------------------------------------------------------------
module i2cbe_front
   import i2cbe_pkg::*;
(
   input  logic [REQ_DATA_W-1:0] data,
   input  logic [CMD_W-1:0]      req_type,
   output item_type              item
);

   always_comb begin
      item.tx_byte   = data[BYTE_W-1:0];
      item.ack_level = data[BYTE_W];
      item.sda_in    = data[BYTE_W+1];
      unique case (req_type)
         CMD_START, CMD_STOP, CMD_SHIFT, CMD_ACK, CMD_UNLOCK: item.cmd = req_type;
         default: item.cmd = CMD_IDLE;  // undefined codes act as plain ticks
      endcase
   end

endmodule

/* hw/rtl/i2cbe_queue.sv */
// ----------------------------------------------------------------------------
// i2cbe_queue
// Small FIFO that decouples the front classifier from the bit engine.
// ----------------------------------------------------------------------------
module i2cbe_queue
   import i2cbe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     not_full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign not_full  = (count_ff != FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/i2cbe_back.sv */
// ----------------------------------------------------------------------------
// i2cbe_back
// Bit engine: runs the line phase sequencer one tick per item and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module i2cbe_back
   import i2cbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output result_type        out_result
);

   logic [TICK_W-1:0]   phase_ticks_ff;
   logic [CMD_W-1:0]    cmd_ff,   cmd_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [BITCNT_W-1:0] bit_ff,   bit_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [TICK_W-1:0]   tick_ff,  tick_in;
   logic [PULSE_W-1:0]  pulse_ff, pulse_in;
   logic                scl_ff,   scl_in;
   logic                sda_ff,   sda_in;
   logic                ack_ff,   ack_in;
   logic [BYTE_W-1:0]   rx_ff,    rx_in;
   logic                valid_ff, valid_in;
   result_type          result_ff, result_in;
   logic [TICK_W-1:0]   limit;
   logic                done;

   assign item_pop   = item_valid && (!valid_ff || out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign limit      = (phase_ticks_ff == '0) ? TICK_W'(1) : phase_ticks_ff;

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      pulse_in = pulse_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;

      if (cmd_ff == CMD_IDLE) begin
         if (item.cmd != CMD_IDLE) begin
            cmd_in   = item.cmd;
            phase_in = PH_0;
            tick_in  = '0;
            unique case (item.cmd)
               CMD_START: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end
               CMD_STOP: begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end
               CMD_SHIFT: begin
                  shift_in = item.tx_byte;
                  bit_in   = '0;
                  scl_in   = 1'b0;
                  sda_in   = item.tx_byte[BYTE_W-1];
               end
               CMD_ACK: begin
                  scl_in = 1'b0;
                  sda_in = item.ack_level;
               end
               default: begin
                  // unlock: a free bus finishes at once
                  pulse_in = '0;
                  if (item.sda_in) begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                  end
               end
            endcase
         end
      end else begin
         tick_in = tick_ff + 1'b1;
         if (tick_in >= limit) begin
            tick_in = '0;
            unique case (cmd_ff)
               CMD_START: begin
                  if (phase_ff == PH_0) begin
                     sda_in   = 1'b0;
                     phase_in = PH_1;
                  end else if (phase_ff == PH_1) begin
                     scl_in   = 1'b0;
                     phase_in = PH_2;
                  end else begin
                     done = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (phase_ff == PH_0) begin
                     scl_in   = 1'b1;
                     phase_in = PH_1;
                  end else begin
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end
               end
               CMD_SHIFT: begin
                  if (phase_ff == PH_0) begin
                     scl_in   = 1'b1;
                     phase_in = PH_1;
                  end else if (phase_ff == PH_1) begin
                     shift_in = {shift_ff[BYTE_W-2:0], item.sda_in};
                     phase_in = PH_2;
                  end else begin
                     scl_in = 1'b0;
                     bit_in = bit_ff + 1'b1;
                     if (bit_in >= BITS_PER_BYTE) begin
                        rx_in = shift_ff;
                        done  = 1'b1;
                     end else begin
                        sda_in   = shift_ff[BYTE_W-1];
                        phase_in = PH_0;
                     end
                  end
               end
               CMD_ACK: begin
                  unique case (phase_ff)
                     PH_0: begin
                        scl_in   = 1'b1;
                        phase_in = PH_1;
                     end
                     PH_1: begin
                        ack_in   = item.sda_in;
                        phase_in = PH_2;
                     end
                     PH_2: begin
                        scl_in   = 1'b0;
                        phase_in = PH_3;
                     end
                     default: begin
                        sda_in = 1'b1;
                        done   = 1'b1;
                     end
                  endcase
               end
               CMD_UNLOCK: begin
                  if (phase_ff == PH_0) begin
                     scl_in   = 1'b1;
                     phase_in = PH_1;
                  end else if (phase_ff == PH_1) begin
                     scl_in   = 1'b0;
                     pulse_in = pulse_ff + 1'b1;
                     phase_in = (pulse_in >= UNLOCK_PULSES || item.sda_in) ? PH_2 : PH_0;
                  end else begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
      end

      if (done) begin
         cmd_in   = CMD_IDLE;
         phase_in = PH_0;
         tick_in  = '0;
      end

      result_in.scl_out     = scl_in;
      result_in.sda_out     = sda_in;
      result_in.rx_byte     = rx_in;
      result_in.ack_sampled = ack_in;
      result_in.done_res    = done;
      result_in.ready_res   = (cmd_in == CMD_IDLE);
      result_in.bus_busy    = !item.sda_in;

      // hold the output until taken, load on every transfer from the queue
      if (item_pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         cmd_ff         <= CMD_IDLE;
         phase_ff       <= PH_0;
         bit_ff         <= '0;
         shift_ff       <= '0;
         tick_ff        <= '0;
         pulse_ff       <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_ff         <= 1'b0;
         rx_ff          <= '0;
         valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         if (item_pop) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            tick_ff  <= tick_in;
            pulse_ff <= pulse_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            rx_ff    <= rx_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master bit engine, one timing tick per request transfer.
// Path: a request is held in the queue, then its result in the output register.
// Throughput: one tick per cycle while rsp_tready does not stall a held result.
// Reset: synchronous; empties the queue, idles the engine, drives the internal
// scl and sda levels high and loads phase_ticks with 7; result_ff is not reset.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
   import i2cbe_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TICK_W-1:0]     csr_wr_data,   // phase_ticks
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] tx_byte, [8] ack_level, [9] sda_in, [15:10] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] scl_out, [1] sda_out, [9:2] rx_byte, [10] ack_sampled, [11] done_res,
   // [12] ready_res, [13] bus_busy, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   item_type   front_item;
   item_type   queue_item;
   logic       queue_not_empty;
   logic       queue_pop;
   result_type result;

   i2cbe_front u_front (
      .data     (req_tdata),
      .req_type (req_tuser),
      .item     (front_item)
   );

   i2cbe_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (front_item),
      .not_full  (req_tready),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   i2cbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (queue_not_empty),
      .item        (queue_item),
      .item_pop    (queue_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, result};

endmodule
